/* hdl/ccm_pkg.sv */
// Package with the script span tables and per-lane match settings for the code map.
package ccm_pkg;

	localparam int NUM_BLOCKS   = 19;
	localparam int NUM_SPANS    = 52;
	localparam int COMMON_FIRST = 46;
	localparam int COMMON_COUNT = 6;
	localparam int BLK_LANES    = 7;
	localparam int LANES        = BLK_LANES + COMMON_COUNT;
	localparam int BLK_W        = $clog2(NUM_BLOCKS + 1);
	localparam int CP_W         = 21;
	localparam int VAL_W        = 14;
	localparam int LEN_W        = 7;
	localparam int CODE_W       = 9;

	localparam logic [BLK_W-1:0] BLK_NONE = BLK_W'(NUM_BLOCKS);

	localparam logic [VAL_W-1:0] SPAN_FIRST [NUM_SPANS] = '{
		14'h483, 14'h591,
		14'h600, 14'h610, 14'h64B, 14'h670, 14'h6D6,
		14'h70F, 14'h730, 14'h7A6,
		14'h901, 14'h93C, 14'h981, 14'h9BC,
		14'hA01, 14'hA3C, 14'hA70, 14'hA81, 14'hABC,
		14'hB01, 14'hB3C, 14'hB56, 14'hB82, 14'hBC0,
		14'hC3E, 14'hCBC, 14'hD41, 14'hDCA,
		14'hE31, 14'hE47, 14'hEB1,
		14'hF18, 14'hF35, 14'hF39, 14'hF71, 14'hF90, 14'hFC6,
		14'h102D, 14'h1058,
		14'h1732, 14'h1752, 14'h17B4, 14'h17C6, 14'h17DD, 14'h18A9, 14'h1920,
		14'h300, 14'h346, 14'h200B, 14'h202A, 14'h2060, 14'h20D0
	};

	localparam logic [VAL_W-1:0] SPAN_LAST [NUM_SPANS] = '{
		14'h489, 14'h5C4,
		14'h603, 14'h615, 14'h658, 14'h670, 14'h6ED,
		14'h711, 14'h74A, 14'h7B0,
		14'h902, 14'h963, 14'h981, 14'h9E3,
		14'hA02, 14'hA4D, 14'hA71, 14'hA82, 14'hAE3,
		14'hB01, 14'hB4D, 14'hB56, 14'hB82, 14'hBCD,
		14'hC56, 14'hCCD, 14'hD4D, 14'hDD6,
		14'hE3A, 14'hE4E, 14'hECD,
		14'hF19, 14'hF35, 14'hF39, 14'hF84, 14'hFBC, 14'hFC6,
		14'h1039, 14'h1059,
		14'h1734, 14'h1753, 14'h17BD, 14'h17D3, 14'h17DD, 14'h18A9, 14'h193B,
		14'h341, 14'h362, 14'h200F, 14'h202E, 14'h206F, 14'h20EA
	};

	localparam logic [CP_W-1:0] BLK_LO [NUM_BLOCKS] = '{
		21'h400, 21'h590, 21'h600, 21'h700, 21'h780, 21'h900, 21'h980,
		21'hA00, 21'hA80, 21'hB00, 21'hB80, 21'hC00, 21'hC80, 21'hD00,
		21'hD80, 21'hF00, 21'h1000, 21'h1720, 21'h1D2B
	};

	localparam logic [CP_W-1:0] BLK_HI [NUM_BLOCKS] = '{
		21'h52F, 21'h5FF, 21'h6FF, 21'h74F, 21'h7B1, 21'h97F, 21'h9FF,
		21'hA7F, 21'hAFF, 21'hB7F, 21'hBFF, 21'hC7F, 21'hCFF, 21'hD7F,
		21'hDFF, 21'hFFF, 21'h108F, 21'h19FF, 21'h1D2B
	};

	localparam int BLK_IDX [NUM_BLOCKS] = '{
		0, 1, 2, 7, 9, 10, 12, 14, 17, 19, 22, 24, 25, 26, 27, 31, 37, 39, 0
	};

	localparam int BLK_CNT [NUM_BLOCKS] = '{
		1, 1, 5, 2, 1, 2, 2, 3, 2, 3, 2, 1, 1, 1, 1, 6, 2, 7, 1
	};

	typedef struct packed {
		logic             en;
		logic [VAL_W-1:0] first;
		logic [LEN_W-1:0] len;
		logic [CODE_W-1:0] code;
	} lane_cfg_t;

	typedef lane_cfg_t [LANES-1:0] lane_row_t;
	typedef lane_row_t [NUM_BLOCKS:0] lane_tab_t;

	typedef struct packed {
		logic             hit_cp;
		logic             hit_code;
		logic [VAL_W-1:0] val_cp;
		logic [VAL_W-1:0] val_code;
	} lane_res_t;

	function automatic lane_tab_t build_lane_tab();
		lane_tab_t tab;
		int code;
		int idx;
		tab = '0;
		for (int b = 0; b <= NUM_BLOCKS; b++) begin
			code = 1;
			for (int k = 0; k < BLK_LANES; k++) begin
				if (b < NUM_BLOCKS && k < BLK_CNT[b]) begin
					idx = BLK_IDX[b] + k;
					tab[b][k].en    = 1'b1;
					tab[b][k].first = SPAN_FIRST[idx];
					tab[b][k].len   = LEN_W'(SPAN_LAST[idx] - SPAN_FIRST[idx]);
					tab[b][k].code  = CODE_W'(code);
					code = code + int'(SPAN_LAST[idx] - SPAN_FIRST[idx]) + 1;
				end
			end
			for (int j = 0; j < COMMON_COUNT; j++) begin
				idx = COMMON_FIRST + j;
				tab[b][BLK_LANES+j].en    = 1'b1;
				tab[b][BLK_LANES+j].first = SPAN_FIRST[idx];
				tab[b][BLK_LANES+j].len   = LEN_W'(SPAN_LAST[idx] - SPAN_FIRST[idx]);
				tab[b][BLK_LANES+j].code  = CODE_W'(code);
				code = code + int'(SPAN_LAST[idx] - SPAN_FIRST[idx]) + 1;
			end
		end
		return tab;
	endfunction

	localparam lane_tab_t LANE_TAB = build_lane_tab();

endpackage

/* hdl/ccm_block_decode.sv */
// First stage: finds the script block that holds the base character.
module ccm_block_decode
	import ccm_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_vld,
	input  logic [CP_W-1:0]   base_char,
	input  logic [CP_W-1:0]   query_value,
	output logic              vld_s1,
	output logic [BLK_W-1:0]  blk_s1,
	output logic [CP_W-1:0]   query_s1
);

	logic [BLK_W-1:0] blk;

	always_comb begin
		blk = BLK_NONE;
		for (int i = NUM_BLOCKS - 1; i >= 0; i--) begin
			if (base_char >= BLK_LO[i] && base_char <= BLK_HI[i]) begin
				blk = BLK_W'(i);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		blk_s1   <= blk;
		query_s1 <= query_value;
	end

endmodule

/* hdl/ccm_lane.sv */
// Second stage lane: tests the query against one span as a code point and as a compact code.
module ccm_lane
	import ccm_pkg::*;
(
	input  logic            clk,
	input  lane_cfg_t       cfg,
	input  logic [CP_W-1:0] query,
	output lane_res_t       res_s2
);

	logic [CP_W:0] d_cp;
	logic [CP_W:0] d_code;
	lane_res_t     res;

	always_comb begin
		d_cp   = {1'b0, query} - {{(CP_W + 1 - VAL_W){1'b0}}, cfg.first};
		d_code = {1'b0, query} - {{(CP_W + 1 - CODE_W){1'b0}}, cfg.code};
		res.hit_cp   = cfg.en && !d_cp[CP_W]
			&& (d_cp[CP_W-1:0] <= {{(CP_W - LEN_W){1'b0}}, cfg.len});
		res.hit_code = cfg.en && !d_code[CP_W]
			&& (d_code[CP_W-1:0] <= {{(CP_W - LEN_W){1'b0}}, cfg.len});
		res.val_cp   = d_cp[VAL_W-1:0] + {{(VAL_W - CODE_W){1'b0}}, cfg.code};
		res.val_code = d_code[VAL_W-1:0] + cfg.first;
	end

	always_ff @(posedge clk) begin
		res_s2 <= res;
	end

endmodule

/* hdl/ccm_select.sv */
// Third stage: picks the first hit in span order and registers the result.
module ccm_select
	import ccm_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             vld_s2,
	input  lane_res_t        res_s2 [LANES],
	output logic             vld_s3,
	output logic [VAL_W-1:0] mapped_s3
);

	logic [VAL_W-1:0] mapped;

	always_comb begin
		mapped = '0;
		for (int k = LANES - 1; k >= 0; k--) begin
			if (res_s2[k].hit_code) begin
				mapped = res_s2[k].val_code;
			end
			if (res_s2[k].hit_cp) begin
				mapped = res_s2[k].val_cp;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else begin
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		mapped_s3 <= mapped;
	end

endmodule

/* hdl/combining_char_code_map.sv */
// Top level of the combining character code map pipeline.
// An accepted start passes through the valid registers vld_s1 and vld_s2 to the registered done strobe.
// Throughput is one transfer per cycle; busy stays low, since the receiver cannot stall.
// Stages are block decode, parallel span lanes, and first-hit selection.
// Asynchronous active-low reset clears the valid bits only.
module combining_char_code_map
	import ccm_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  logic [CP_W-1:0]  base_char,
	input  logic [CP_W-1:0]  query_value,
	output logic             done,
	output logic [VAL_W-1:0] mapped_value
);

	logic             vld_s1;
	logic [BLK_W-1:0] blk_s1;
	logic [CP_W-1:0]  query_s1;
	logic             vld_s2;
	lane_row_t        row;
	lane_res_t        res_s2 [LANES];

	assign busy = 1'b0;

	ccm_block_decode u_decode (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_vld      (start & ~busy),
		.base_char   (base_char),
		.query_value (query_value),
		.vld_s1      (vld_s1),
		.blk_s1      (blk_s1),
		.query_s1    (query_s1)
	);

	assign row = LANE_TAB[blk_s1];

	for (genvar k = 0; k < LANES; k++) begin : g_lane
		ccm_lane u_lane (
			.clk    (clk),
			.cfg    (row[k]),
			.query  (query_s1),
			.res_s2 (res_s2[k])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else begin
			vld_s2 <= vld_s1;
		end
	end

	ccm_select u_select (
		.clk       (clk),
		.arst_n    (arst_n),
		.vld_s2    (vld_s2),
		.res_s2    (res_s2),
		.vld_s3    (done),
		.mapped_s3 (mapped_value)
	);

endmodule

/* tb/tb_combining_char_code_map.sv */
// Testbench for the combining character code map with a span-table scoreboard.
`timescale 1ns / 1ps

module tb_combining_char_code_map
	import ccm_pkg::*;
();

	localparam int N_SCRIPTS     = 19;
	localparam int COMMON_SPAN   = 46;
	localparam int COMMON_NSPAN  = 6;
	localparam int N_RANDOM      = 600;
	localparam int IDLE_LIMIT    = 500;
	localparam int SETTLE_CYCLES = 8;

	localparam int CP_FIRST [52] = '{
		'h483, 'h591,
		'h600, 'h610, 'h64B, 'h670, 'h6D6,
		'h70F, 'h730, 'h7A6,
		'h901, 'h93C, 'h981, 'h9BC,
		'hA01, 'hA3C, 'hA70, 'hA81, 'hABC,
		'hB01, 'hB3C, 'hB56, 'hB82, 'hBC0,
		'hC3E, 'hCBC, 'hD41, 'hDCA,
		'hE31, 'hE47, 'hEB1,
		'hF18, 'hF35, 'hF39, 'hF71, 'hF90, 'hFC6,
		'h102D, 'h1058,
		'h1732, 'h1752, 'h17B4, 'h17C6, 'h17DD, 'h18A9, 'h1920,
		'h300, 'h346, 'h200B, 'h202A, 'h2060, 'h20D0
	};

	localparam int CP_LAST [52] = '{
		'h489, 'h5C4,
		'h603, 'h615, 'h658, 'h670, 'h6ED,
		'h711, 'h74A, 'h7B0,
		'h902, 'h963, 'h981, 'h9E3,
		'hA02, 'hA4D, 'hA71, 'hA82, 'hAE3,
		'hB01, 'hB4D, 'hB56, 'hB82, 'hBCD,
		'hC56, 'hCCD, 'hD4D, 'hDD6,
		'hE3A, 'hE4E, 'hECD,
		'hF19, 'hF35, 'hF39, 'hF84, 'hFBC, 'hFC6,
		'h1039, 'h1059,
		'h1734, 'h1753, 'h17BD, 'h17D3, 'h17DD, 'h18A9, 'h193B,
		'h341, 'h362, 'h200F, 'h202E, 'h206F, 'h20EA
	};

	localparam int SCRIPT_LO [N_SCRIPTS] = '{
		'h400, 'h590, 'h600, 'h700, 'h780, 'h900, 'h980, 'hA00, 'hA80, 'hB00,
		'hB80, 'hC00, 'hC80, 'hD00, 'hD80, 'hF00, 'h1000, 'h1720, 'h1D2B
	};

	localparam int SCRIPT_HI [N_SCRIPTS] = '{
		'h52F, 'h5FF, 'h6FF, 'h74F, 'h7B1, 'h97F, 'h9FF, 'hA7F, 'hAFF, 'hB7F,
		'hBFF, 'hC7F, 'hCFF, 'hD7F, 'hDFF, 'hFFF, 'h108F, 'h19FF, 'h1D2B
	};

	localparam int SCRIPT_SPAN [N_SCRIPTS] = '{
		0, 1, 2, 7, 9, 10, 12, 14, 17, 19, 22, 24, 25, 26, 27, 31, 37, 39, 0
	};

	localparam int SCRIPT_NSPAN [N_SCRIPTS] = '{
		1, 1, 5, 2, 1, 2, 2, 3, 2, 3, 2, 1, 1, 1, 1, 6, 2, 7, 1
	};

	typedef struct {
		logic [CP_W-1:0]  base;
		logic [CP_W-1:0]  query;
		logic [VAL_W-1:0] expected;
	} map_query_t;

	class code_map_tracker;
		map_query_t  pending_codes[$];
		int unsigned errors;

		function new();
			errors = 0;
		endfunction

		// Codes run on from one span to the next, so the running code is carried across calls.
		function int unsigned scan_spans(int first_span, int nspan, int unsigned q,
				inout int unsigned code);
			int unsigned lo;
			int unsigned len;
			for (int k = 0; k < nspan; k++) begin
				lo  = CP_FIRST[first_span + k];
				len = CP_LAST[first_span + k] - lo;
				if (q >= lo && q - lo <= len)
					return q - lo + code;
				if (q >= code && q - code <= len)
					return q - code + lo;
				code += len + 1;
			end
			return 0;
		endfunction

		function logic [VAL_W-1:0] map_char(logic [CP_W-1:0] base, logic [CP_W-1:0] query);
			int unsigned code;
			int unsigned hit;
			code = 1;
			hit  = 0;
			for (int i = 0; i < N_SCRIPTS && hit == 0; i++)
				if (base >= SCRIPT_LO[i] && base <= SCRIPT_HI[i])
					hit = scan_spans(SCRIPT_SPAN[i], SCRIPT_NSPAN[i], query, code);
			if (hit == 0)
				hit = scan_spans(COMMON_SPAN, COMMON_NSPAN, query, code);
			return VAL_W'(hit);
		endfunction

		function void note_query(logic [CP_W-1:0] base, logic [CP_W-1:0] query);
			map_query_t item;
			item.base     = base;
			item.query    = query;
			item.expected = map_char(base, query);
			pending_codes.push_back(item);
		endfunction

		function void check_code(logic [VAL_W-1:0] actual);
			map_query_t item;
			if (pending_codes.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected result: mapped_value %h", actual);
			end else begin
				item = pending_codes.pop_front();
				if (actual !== item.expected) begin
					errors++;
					if (errors <= 10)
						$display("mismatch: base %h query %h expected %h actual %h",
							item.base, item.query, item.expected, actual);
				end
			end
		endfunction

		function int unsigned outstanding();
			return pending_codes.size();
		endfunction

		function void close_out();
			if (pending_codes.size() != 0) begin
				errors += pending_codes.size();
				$display("%0d results never arrived", pending_codes.size());
			end
		endfunction
	endclass

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             start = 1'b0;
	logic             busy;
	logic [CP_W-1:0]  base_char = '0;
	logic [CP_W-1:0]  query_value = '0;
	logic             done;
	logic [VAL_W-1:0] mapped_value;

	code_map_tracker tracker = new();
	int              idle_cycles = 0;

	combining_char_code_map i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.base_char    (base_char),
		.query_value  (query_value),
		.done         (done),
		.mapped_value (mapped_value)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy)
				tracker.note_query(base_char, query_value);
			if (done)
				tracker.check_code(mapped_value);
			if ((start && !busy) || done) begin
				idle_cycles <= 0;
			end else if (idle_cycles >= IDLE_LIMIT) begin
				$display("simulation failed");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

	task automatic send_query(input logic [CP_W-1:0] b, input logic [CP_W-1:0] q);
		start       <= 1'b1;
		base_char   <= b;
		query_value <= q;
		do @(posedge clk); while (busy);
	endtask

	task automatic pause_sender(input int cycles);
		start <= 1'b0;
		repeat (cycles) @(posedge clk);
	endtask

	task automatic drain_results();
		start <= 1'b0;
		do @(posedge clk); while (tracker.outstanding() > 0);
	endtask

	initial begin
		int               sent;
		int               burst;
		int               script;
		int               span;
		logic [CP_W-1:0]  b;
		logic [CP_W-1:0]  q;

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_query(21'h000000, 21'h000000);
		send_query(21'h110000, 21'h000300);
		send_query(21'h1FFFFF, 21'h000001);
		send_query(21'h001D2B, 21'h000483);
		send_query(21'h001D2B, 21'h000300);
		send_query(21'h001D2A, 21'h0020EA);
		send_query(21'h001D2C, 21'h1FFFFF);
		send_query(21'h000400, 21'h000489);
		send_query(21'h00052F, 21'h000007);
		send_query(21'h0003FF, 21'h000483);
		send_query(21'h000530, 21'h00000D);
		send_query(21'h000590, 21'h0005C4);
		send_query(21'h0006FF, 21'h0006ED);
		send_query(21'h001720, 21'h00193B);
		send_query(21'h0019FF, 21'h00003B);
		send_query(21'h000F00, 21'h000FC6);
		send_query(21'h00108F, 21'h001059);
		send_query(21'h0007B1, 21'h0007B0);
		send_query(21'h00097F, 21'h0020D0);
		send_query(21'h000DFF, 21'h000015);
		send_query(21'h155555, 21'h0AAAAA);
		send_query(21'h0AAAAA, 21'h155555);
		send_query(21'h10FFFF, 21'h00200B);
		drain_results();

		sent = 0;
		while (sent < N_RANDOM) begin
			burst = $urandom_range(1, 24);
			for (int k = 0; k < burst && sent < N_RANDOM; k++) begin
				script = $urandom_range(0, N_SCRIPTS - 1);
				case ($urandom_range(0, 9))
					0: b = CP_W'($urandom);
					1: b = CP_W'($urandom_range(21'h110000, 21'h1FFFFF));
					2: b = CP_W'($urandom_range(0, 21'h3FF));
					default: b = CP_W'($urandom_range(SCRIPT_LO[script], SCRIPT_HI[script]));
				endcase
				case ($urandom_range(0, 9))
					0, 1: q = CP_W'($urandom);
					2, 3, 4: q = CP_W'($urandom_range(0, 260));
					5, 6, 7: begin
						span = SCRIPT_SPAN[script] + $urandom_range(0, SCRIPT_NSPAN[script] - 1);
						q = CP_W'($urandom_range(CP_FIRST[span] - 1, CP_LAST[span] + 1));
					end
					default: begin
						span = COMMON_SPAN + $urandom_range(0, COMMON_NSPAN - 1);
						q = CP_W'($urandom_range(CP_FIRST[span] - 1, CP_LAST[span] + 1));
					end
				endcase
				send_query(b, q);
				sent++;
			end
			case ($urandom_range(0, 9))
				0, 1, 2: ;
				3: drain_results();
				default: pause_sender($urandom_range(1, 12));
			endcase
		end

		drain_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
		tracker.close_out();
		if (tracker.errors == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
